@@ rtl/core/alid_pkg.sv @@
// shared types and constants for the array list insert/delete block
`default_nettype none

package alid_pkg;

  // number of entry cells in the row
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STAT_W   = 2;

  // stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [CNT_W-1:0] CAP_LIMIT_RESET = CNT_W'(10);
  localparam logic [CNT_W-1:0] CAPACITY_CNT    = CNT_W'(CAPACITY);

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADIDX = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } alid_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/alid_cell.sv @@
// one entry cell of the list: holds a value and shifts with its neighbors
`default_nettype none

module alid_cell (
  input  wire                                    clk_i,
  input  wire [alid_pkg::IDX_W-1:0]              idx_i,
  input  wire alid_pkg::alid_ctrl_t              ctrl_i,
  input  wire signed [alid_pkg::DATA_W-1:0]      left_i,
  input  wire signed [alid_pkg::DATA_W-1:0]      right_i,
  output logic signed [alid_pkg::DATA_W-1:0]     entry_o,
  output logic signed [alid_pkg::DATA_W-1:0]     sel_o
);
  import alid_pkg::*;

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic [CNT_W-1:0]         idx_ext;
  logic                     at_pos, above_pos;

  // compare own index with the requested position
  assign idx_ext   = CNT_W'(idx_i);
  assign at_pos    = (idx_ext == ctrl_i.pos);
  assign above_pos = (idx_ext > ctrl_i.pos);

  // insert shifts up from the left neighbor, delete pulls from the right
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        entry_d = ctrl_i.value;
      end else if (above_pos) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (at_pos || above_pos) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // current value when this cell is the addressed one, for the removed item
  assign sel_o   = at_pos ? entry_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/array_list_insert_delete_top.sv @@
// Packed ordered list of signed 32-bit values with append, insert and delete.
// Channels: the slave stream takes one request item (tuser: req_type; tdata:
// position, value), the master stream returns exactly one result item per
// request (tuser: status; tdata: removed_value, entry_count). A separate
// write channel (cfg_valid_i/cfg_ready_o/cfg_data_i), always ready, sets
// capacity_limit; write it only while no request is in flight (unenforced).
// Each entry lives in its own cell; all cells compare their index with the
// position and shift to or from a neighbor in the same cycle, so a request
// is fully applied in the cycle it is accepted.
// Result: registered when the request is taken, valid in the next cycle.
// Throughput: one item per cycle, set by the single result register; a new
// request is taken whenever the result register is empty or being drained.
// Receiver stall: the result is held in the output register and the request
// side stops accepting until it is taken.
// Reset: the list is empty, capacity_limit is 10, no result is pending.
// Entries are not cleared; only positions below the count are ever read.
`default_nettype none

module array_list_insert_delete_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration write
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [alid_pkg::CNT_W-1:0]            cfg_data_i,      // capacity_limit
  // request stream
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire [alid_pkg::S_TDATA_W-1:0]        s_axis_tdata_i,  // position[4:0], value[36:5]
  input  wire [alid_pkg::REQ_W-1:0]            s_axis_tuser_i,  // req_type[1:0]
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  output logic [alid_pkg::M_TDATA_W-1:0]       m_axis_tdata_o,  // removed_value[31:0], entry_count[36:32]
  output logic [alid_pkg::STAT_W-1:0]          m_axis_tuser_o   // status[1:0]
);
  import alid_pkg::*;

  logic [CNT_W-1:0]         cap_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q;
  logic [STAT_W-1:0]        status_q, status_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;
  logic [CNT_W-1:0]         count_out_q;

  logic                     accept;
  req_e                     req;
  logic [CNT_W-1:0]         pos;
  logic signed [DATA_W-1:0] val;
  logic [CNT_W-1:0]         limit;
  logic                     full;
  logic signed [DATA_W-1:0] removed_or;
  alid_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] entry_w [CAPACITY];
  logic signed [DATA_W-1:0] sel_w   [CAPACITY];

  // unpack request fields
  assign req = req_e'(s_axis_tuser_i);
  assign pos = s_axis_tdata_i[CNT_W-1:0];
  assign val = s_axis_tdata_i[CNT_W +: DATA_W];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // limit in force and full check
  assign limit = (cap_q < CAPACITY_CNT) ? cap_q : CAPACITY_CNT;
  assign full  = (count_q >= limit);

  // value at the addressed cell
  always_comb begin
    removed_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_or = removed_or | sel_w[i];
    end
  end

  // removed value only for a delete inside the list
  assign removed_d = ((req == REQ_DELETE) && (pos < count_q)) ? removed_or : '0;

  // decode request into cell command, status and new count
  always_comb begin
    ctrl       = '0;
    ctrl.value = val;
    ctrl.pos   = pos;
    status_d   = ST_DONE;
    count_d    = count_q;
    case (req)
      REQ_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = accept;
          ctrl.pos = count_q;
          count_d  = count_q + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (pos > count_q) begin
          status_d = ST_BADIDX;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = accept;
          count_d  = count_q + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (pos >= count_q) begin
          status_d = ST_BADIDX;
        end else begin
          ctrl.del  = accept;
          count_d   = count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  // row of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    alid_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[g]),
      .sel_o   (sel_w[g])
    );
  end

  // control state: count, limit register, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_LIMIT_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      removed_q   <= removed_d;
      count_out_q <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - DATA_W - CNT_W)'(0), count_out_q, removed_q};

endmodule

`default_nettype wire

@@ tb/array_list_insert_delete_tb.sv @@
// self-checking testbench for the array list insert/delete block
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import alid_pkg::*;

  // one expected result item
  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] removed;
    logic [CNT_W-1:0]         count;
  } list_result_t;

  // list predictor and result checker
  class list_scoreboard;
    logic signed [DATA_W-1:0] cells [CAPACITY];
    logic [CNT_W-1:0]         fill;
    logic [CNT_W-1:0]         limit_reg;
    list_result_t             expected_q[$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              op_seen [4];
    int unsigned              full_seen;
    int unsigned              badidx_seen;
    int unsigned              peak_fill;

    function new();
      fill      = '0;
      limit_reg = CAP_LIMIT_RESET;
      errors    = 0;
      checked   = 0;
      full_seen = 0;
      badidx_seen = 0;
      peak_fill = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] lim);
      limit_reg = lim;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted request to the list copy and queue its result
    function void note_request(req_e op, logic [CNT_W-1:0] pos, logic signed [DATA_W-1:0] val);
      list_result_t r;
      int lim;
      int i;
      r.status  = ST_DONE;
      r.removed = '0;
      lim = (limit_reg < CAPACITY) ? int'(limit_reg) : int'(CAPACITY);
      op_seen[op] += 1;
      case (op)
        REQ_APPEND: begin
          if (int'(fill) >= lim) begin
            r.status = ST_FULL;
          end else begin
            cells[fill] = val;
            fill = fill + 1'b1;
          end
        end
        REQ_INSERT: begin
          // position is checked ahead of the full condition
          if (pos > fill) begin
            r.status = ST_BADIDX;
          end else if (int'(fill) >= lim) begin
            r.status = ST_FULL;
          end else begin
            for (i = int'(fill); i > int'(pos); i--) cells[i] = cells[i-1];
            cells[pos] = val;
            fill = fill + 1'b1;
          end
        end
        REQ_DELETE: begin
          if (pos >= fill) begin
            r.status = ST_BADIDX;
          end else begin
            r.removed = cells[pos];
            for (i = int'(pos); i + 1 < int'(fill); i++) cells[i] = cells[i+1];
            fill = fill - 1'b1;
          end
        end
        default: ;
      endcase
      r.count = fill;
      if (r.status == ST_FULL) full_seen++;
      if (r.status == ST_BADIDX) badidx_seen++;
      if (fill > peak_fill) peak_fill = fill;
      expected_q.push_back(r);
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(status_e st, logic signed [DATA_W-1:0] rem,
                               logic [CNT_W-1:0] cnt);
      list_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item: status %0d removed %0d count %0d",
                 $time, st, rem, cnt);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (st !== e.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (rem !== e.removed) begin
        $display("%0t: removed_value mismatch: expected %0d actual %0d",
                 $time, e.removed, rem);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: entry_count mismatch: expected %0d actual %0d", $time, e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic [REQ_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [STAT_W-1:0]      m_tuser;

  bit                     tx_idle;
  bit                     rx_idle;
  int                     rx_stall_left;

  list_scoreboard         sb = new();

  array_list_insert_delete_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 7) == 0) begin
      rx_stall_left <= $urandom_range(1, 15) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watch all three handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
      if (s_tvalid && s_tready)
        sb.note_request(req_e'(s_tuser), s_tdata[CNT_W-1:0], s_tdata[CNT_W +: DATA_W]);
      if (m_tvalid && m_tready)
        sb.check_result(status_e'(m_tuser), m_tdata[DATA_W-1:0], m_tdata[DATA_W +: CNT_W]);
    end
  end

  // present one request item and hold it until taken
  task automatic send_request(req_e op, int pos, logic [DATA_W-1:0] val);
    int gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, val, 5'(pos)};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait until every result has come back
  task automatic settle_list();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  // new capacity limit, written only with the block idle
  task automatic reconfigure(logic [CNT_W-1:0] lim);
    settle_list();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random mix of mostly well-formed requests, swinging between growth and shrinkage
  task automatic run_mix(int n_items, bit allow_idle);
    req_e             op;
    int               pos;
    int               fill_now;
    int               grow_pct;
    int               roll;
    logic [DATA_W-1:0] val;
    grow_pct = 75;
    for (int n = 0; n < n_items; n++) begin
      if (n % 32 == 0) begin
        grow_pct = (grow_pct == 75) ? 25 : 75;
        tx_idle  = allow_idle && ($urandom_range(0, 3) != 0);
        rx_idle  = allow_idle && ($urandom_range(0, 3) != 0);
      end
      fill_now = sb.fill;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any code, any position
        op  = req_e'($urandom_range(0, 3));
        pos = $urandom_range(0, 31);
      end else if ($urandom_range(0, 99) < grow_pct) begin
        op  = ($urandom_range(0, 1) == 0) ? REQ_APPEND : REQ_INSERT;
        pos = (op == REQ_APPEND) ? $urandom_range(0, 31) : $urandom_range(0, fill_now);
      end else begin
        op  = REQ_DELETE;
        pos = (fill_now == 0) ? 0 : $urandom_range(0, fill_now - 1);
      end
      case ($urandom_range(0, 15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = 32'h0000_0000;
        3:       val = 32'hffff_ffff;
        default: val = $urandom;
      endcase
      send_request(op, pos, val);
      if ($urandom_range(0, 99) == 0) settle_list();
    end
  endtask

  // main sequence
  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = REQ_NONE;
    m_tready      = 1'b0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    rx_stall_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, edges of position and value, default limit
    send_request(REQ_DELETE, 0, 32'h1234_5678);
    send_request(REQ_INSERT, 1, 32'h0000_0005);
    send_request(REQ_NONE, 31, 32'hdead_beef);
    send_request(REQ_INSERT, 0, 32'h7fff_ffff);
    send_request(REQ_APPEND, 31, 32'h8000_0000);
    send_request(REQ_INSERT, 1, 32'hffff_ffff);
    send_request(REQ_INSERT, 3, 32'h0000_0000);
    send_request(REQ_APPEND, 0, 32'h0000_0001);
    send_request(REQ_DELETE, 5, 32'h0);
    send_request(REQ_DELETE, 31, 32'h0);
    send_request(REQ_INSERT, 31, 32'h5555_aaaa);
    send_request(REQ_INSERT, 6, 32'haaaa_5555);
    send_request(REQ_DELETE, 2, 32'hffff_ffff);
    send_request(REQ_DELETE, 0, 32'h0);
    send_request(REQ_DELETE, 2, 32'h0);

    // limit lowered to the current count: full, but bad index still wins
    reconfigure(5'd2);
    send_request(REQ_APPEND, 0, 32'h0000_0042);
    send_request(REQ_INSERT, 0, 32'h0000_0043);
    send_request(REQ_INSERT, 5, 32'h0000_0044);
    send_request(REQ_NONE, 0, 32'h0);
    send_request(REQ_DELETE, 1, 32'h0);

    // zero limit: nothing may be added, deletes still work
    reconfigure(5'd0);
    send_request(REQ_APPEND, 0, 32'h0000_0099);
    send_request(REQ_INSERT, 0, 32'h0000_0098);
    send_request(REQ_DELETE, 0, 32'h0);
    send_request(REQ_DELETE, 0, 32'h0);

    // random phases across the limit range
    reconfigure(5'd16);
    run_mix(120, 1'b1);
    reconfigure(5'd1);
    run_mix(80, 1'b1);
    reconfigure(5'd31);
    run_mix(120, 1'b1);
    reconfigure(5'd0);
    run_mix(40, 1'b1);
    reconfigure(5'd7);
    run_mix(100, 1'b1);
    reconfigure(5'(sb.fill > 1 ? sb.fill - 1 : 1));
    run_mix(60, 1'b1);
    reconfigure(5'($urandom_range(1, 16)));
    run_mix(110, 1'b1);
    reconfigure(5'd16);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_mix(120, 1'b0);

    // drain and finish
    settle_list();
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("run covered %0d results: %0d appends, %0d inserts, %0d deletes, %0d unused codes",
             sb.checked, sb.op_seen[REQ_APPEND], sb.op_seen[REQ_INSERT],
             sb.op_seen[REQ_DELETE], sb.op_seen[REQ_NONE]);
    $display("%0d list-full and %0d bad-index refusals, deepest list %0d entries",
             sb.full_seen, sb.badidx_seen, sb.peak_fill);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
